// ===== rtl/tlas_pkg.sv =====
// Shared types, constants, microprogram and lookup functions for the arm angle solver.
`default_nettype none
package tlas_pkg;

	localparam int ANG_W   = 22;
	localparam int RAT_W   = 18;
	localparam int CORD_W  = 20;
	localparam int DIV_W   = 49;
	localparam int DEN_W   = 32;
	localparam int RAD_W   = 34;
	localparam int ROOT_W  = 17;
	localparam int PC_W    = 5;
	localparam int PROG_LEN = 29;

	localparam logic signed [ANG_W-1:0]  ANG_PI      = 22'sd205887;
	localparam logic signed [ANG_W-1:0]  ANG_TWO_PI  = 22'sd411774;
	localparam logic signed [ANG_W-1:0]  ANG_HALF_PI = 22'sd102944;
	localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 20'sd39797;
	localparam logic signed [RAT_W-1:0]  ONE_Q16     = 18'sd65536;
	localparam logic signed [RAT_W-1:0]  SQRT_HALF   = 18'sd46340;
	localparam logic signed [RAT_W-1:0]  NEAR_ONE    = 18'sd65529;
	localparam logic [DIV_W-1:0]         RAT_MAX     = 49'd131071;
	localparam logic signed [15:0]       LOW_Z_LIMIT = -16'sd7680;

	localparam logic [1:0] REG_UPPER = 2'd0;
	localparam logic [1:0] REG_FORE  = 2'd1;

	typedef enum logic [4:0] {
		OP_MUL_XX, OP_MUL_ZZ, OP_SQRT_R2, OP_MUL_AA, OP_MUL_FF, OP_MUL_AL,
		OP_DIV_ZR, OP_DIV_XR, OP_SETU_XR, OP_MUL_UU, OP_SQRT_U, OP_VEC_U,
		OP_SAVE_A, OP_SETU_ZR, OP_SHOULDER, OP_ROT_SH, OP_MUL_ACO, OP_DIV_C,
		OP_MUL_ASI, OP_DIV_S, OP_SETU_EL, OP_ELBOW, OP_FINISH
	} op_t;

	typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT} state_t;

	typedef struct packed {
		logic load;
		logic start;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic done;
	} sts_t;

	function automatic op_t prog_op(input logic [PC_W-1:0] pc);
		op_t o;
		case (pc)
			5'd0:  o = OP_MUL_XX;
			5'd1:  o = OP_MUL_ZZ;
			5'd2:  o = OP_SQRT_R2;
			5'd3:  o = OP_MUL_AA;
			5'd4:  o = OP_MUL_FF;
			5'd5:  o = OP_MUL_AL;
			5'd6:  o = OP_DIV_ZR;
			5'd7:  o = OP_DIV_XR;
			5'd8:  o = OP_SETU_XR;
			5'd9:  o = OP_MUL_UU;
			5'd10: o = OP_SQRT_U;
			5'd11: o = OP_VEC_U;
			5'd12: o = OP_SAVE_A;
			5'd13: o = OP_SETU_ZR;
			5'd14: o = OP_MUL_UU;
			5'd15: o = OP_SQRT_U;
			5'd16: o = OP_VEC_U;
			5'd17: o = OP_SHOULDER;
			5'd18: o = OP_ROT_SH;
			5'd19: o = OP_MUL_ACO;
			5'd20: o = OP_DIV_C;
			5'd21: o = OP_MUL_ASI;
			5'd22: o = OP_DIV_S;
			5'd23: o = OP_SETU_EL;
			5'd24: o = OP_MUL_UU;
			5'd25: o = OP_SQRT_U;
			5'd26: o = OP_VEC_U;
			5'd27: o = OP_ELBOW;
			default: o = OP_FINISH;
		endcase
		return o;
	endfunction

	function automatic logic signed [CORD_W-1:0] atan_q16(input logic [3:0] i);
		logic signed [CORD_W-1:0] v;
		case (i)
			4'd0:  v = 20'sd51472;
			4'd1:  v = 20'sd30386;
			4'd2:  v = 20'sd16055;
			4'd3:  v = 20'sd8150;
			4'd4:  v = 20'sd4091;
			4'd5:  v = 20'sd2047;
			4'd6:  v = 20'sd1024;
			4'd7:  v = 20'sd512;
			4'd8:  v = 20'sd256;
			4'd9:  v = 20'sd128;
			4'd10: v = 20'sd64;
			4'd11: v = 20'sd32;
			4'd12: v = 20'sd16;
			4'd13: v = 20'sd8;
			4'd14: v = 20'sd4;
			default: v = 20'sd2;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/tlas_ctrl.sv =====
// Controller that steps the datapath through the solver microprogram.
`default_nettype none
module tlas_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output tlas_pkg::cmd_t     cmd,
	input  wire tlas_pkg::sts_t sts
);
	import tlas_pkg::*;

	state_t          st_q, st_d;
	logic [PC_W-1:0] pc_q, pc_d;
	logic            out_valid_q;
	logic            out_set;
	localparam logic [PC_W-1:0] LAST_PC = PC_W'(PROG_LEN - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			pc_q <= pc_d;
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		st_d      = st_q;
		pc_d      = pc_q;
		cmd.op    = prog_op(pc_q);
		cmd.load  = 1'b0;
		cmd.start = 1'b0;
		s_tready  = 1'b0;
		out_set   = 1'b0;
		case (st_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					pc_d     = '0;
					st_d     = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				// The result register must be free before the final step writes it.
				if (!(cmd.op == OP_FINISH && out_valid_q && !m_tready)) begin
					cmd.start = 1'b1;
					st_d      = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (sts.done) begin
					if (pc_q == LAST_PC) begin
						out_set = 1'b1;
						st_d    = ST_IDLE;
					end else begin
						pc_d = pc_q + 1'b1;
						st_d = ST_ISSUE;
					end
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	assign m_tvalid = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/tlas_dp.sv =====
// Datapath with shared multiplier, square root, divider and CORDIC units.
`default_nettype none
module tlas_dp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic [1:0]     cfg_index,
	input  wire logic [14:0]    cfg_data,
	input  wire logic [31:0]    s_tdata,
	input  wire tlas_pkg::cmd_t cmd,
	output tlas_pkg::sts_t      sts,
	output logic [87:0]         m_tdata
);
	import tlas_pkg::*;

	logic signed [15:0]        x_q, z_q;
	logic [14:0]               upper_q, fore_q;
	logic [31:0]               r2_q;
	logic [15:0]               len_q;
	logic signed [31:0]        t_q;
	logic [DEN_W-1:0]          den_q;
	logic signed [RAT_W-1:0]   zr_q, xr_q, c_q, s_q, u_q;
	logic signed [CORD_W-1:0]  tang_q, co_q, si_q;
	logic signed [ANG_W-1:0]   sh_q, el_q;
	logic                      err_q, acase_q;
	op_t                       op_q;
	logic                      imm_q;

	logic signed [17:0]        mul_a_q, mul_b_q, mul_a_d, mul_b_d;
	logic signed [35:0]        prod_q;
	logic                      mul_run_q, mul_fin_q;

	logic [RAD_W-1:0]          rad_q, rad_d;
	logic [ROOT_W-1:0]         root_q;
	logic [18:0]               rem_q;
	logic [4:0]                sq_cnt_q;
	logic                      sq_run_q, sq_fin_q;
	logic [20:0]               sq_part, sq_trial;

	logic [DIV_W-1:0]          dvd_q, quo_q;
	logic [DEN_W-1:0]          dden_q, drem_q, div_den;
	logic signed [49:0]        div_num, div_neg;
	logic signed [33:0]        xr_sum;
	logic signed [35:0]        cs_num;
	logic                      dneg_q;
	logic [5:0]                dv_cnt_q;
	logic                      dv_run_q, dv_fin_q;
	logic [DEN_W:0]            dv_trial;
	logic [16:0]               qmag;
	logic signed [RAT_W-1:0]   qs;

	logic signed [CORD_W-1:0]  cx_q, cy_q, cz_q, cxs, cys, cat;
	logic [3:0]                c_cnt_q;
	logic                      cmode_q, cneg_q, c_run_q, c_fin_q;
	logic signed [ANG_W-1:0]   fold;
	logic                      fold_neg;

	logic signed [15:0]        last_sh_q, last_el_q, wacc_q;
	logic [80:0]               out_q;
	logic signed [15:0]        sh12, el12, wr, shc, elc;
	logic                      fin, is_mul, is_sqrt, is_div, is_cord;
	logic                      asin_case, s_in_range;

	function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
		if (v > 24'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -24'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	function automatic logic signed [RAT_W-1:0] clamp_unit(input logic signed [RAT_W-1:0] v);
		if (v > ONE_Q16) begin
			return ONE_Q16;
		end else if (v < -ONE_Q16) begin
			return -ONE_Q16;
		end
		return v;
	endfunction

	function automatic logic beyond_unit(input logic signed [RAT_W-1:0] v);
		return (v > ONE_Q16) || (v < -ONE_Q16);
	endfunction

	always_comb begin
		is_mul  = 1'b0;
		is_sqrt = 1'b0;
		is_div  = 1'b0;
		is_cord = 1'b0;
		case (cmd.op)
			OP_MUL_XX, OP_MUL_ZZ, OP_MUL_AA, OP_MUL_FF, OP_MUL_AL, OP_MUL_UU,
			OP_MUL_ACO, OP_MUL_ASI: is_mul = 1'b1;
			OP_SQRT_R2, OP_SQRT_U: is_sqrt = 1'b1;
			OP_DIV_ZR, OP_DIV_XR, OP_DIV_C, OP_DIV_S: is_div = 1'b1;
			OP_VEC_U, OP_ROT_SH: is_cord = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		mul_a_d = '0;
		mul_b_d = '0;
		case (cmd.op)
			OP_MUL_XX: begin mul_a_d = 18'(x_q); mul_b_d = 18'(x_q); end
			OP_MUL_ZZ: begin mul_a_d = 18'(z_q); mul_b_d = 18'(z_q); end
			OP_MUL_AA: begin mul_a_d = {3'b0, upper_q}; mul_b_d = {3'b0, upper_q}; end
			OP_MUL_FF: begin mul_a_d = {3'b0, fore_q}; mul_b_d = {3'b0, fore_q}; end
			OP_MUL_AL: begin mul_a_d = {3'b0, upper_q}; mul_b_d = {2'b0, len_q}; end
			OP_MUL_UU: begin mul_a_d = u_q; mul_b_d = u_q; end
			OP_MUL_ACO: begin mul_a_d = {3'b0, upper_q}; mul_b_d = co_q[17:0]; end
			OP_MUL_ASI: begin mul_a_d = {3'b0, upper_q}; mul_b_d = si_q[17:0]; end
			default: ;
		endcase
	end

	always_comb begin
		rad_d = {2'b0, r2_q};
		if (cmd.op == OP_SQRT_U) begin
			rad_d = 34'h1_0000_0000 - {1'b0, prod_q[32:0]};
		end
	end

	always_comb begin
		xr_sum  = $signed({t_q[31], t_q[31], t_q}) + $signed({2'b0, r2_q});
		cs_num  = 36'($signed({x_q, 16'h0})) - prod_q;
		div_num = 50'($signed({z_q, 16'h0}));
		div_den = {16'b0, len_q};
		case (cmd.op)
			OP_DIV_XR: begin
				div_num = $signed({xr_sum, 16'h0});
				div_den = den_q;
			end
			OP_DIV_C: begin
				div_num = 50'(cs_num);
				div_den = {17'b0, fore_q};
			end
			OP_DIV_S: begin
				cs_num  = 36'($signed({z_q, 16'h0})) - prod_q;
				div_num = 50'(cs_num);
				div_den = {17'b0, fore_q};
			end
			default: ;
		endcase
		div_neg = -div_num;
	end

	always_comb begin
		fold     = sh_q;
		fold_neg = 1'b0;
		if (fold > ANG_PI) fold = fold - ANG_TWO_PI;
		if (fold < -ANG_PI) fold = fold + ANG_TWO_PI;
		if (fold > ANG_HALF_PI) begin
			fold     = fold - ANG_PI;
			fold_neg = 1'b1;
		end else if (fold < -ANG_HALF_PI) begin
			fold     = fold + ANG_PI;
			fold_neg = 1'b1;
		end
	end

	assign sq_part  = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign sq_trial = {2'b0, root_q, 2'b01};
	assign dv_trial = {drem_q, dvd_q[DIV_W-1]};
	assign cxs      = cx_q >>> c_cnt_q;
	assign cys      = cy_q >>> c_cnt_q;
	assign cat      = atan_q16(c_cnt_q);

	assign qmag = (quo_q > RAT_MAX) ? 17'h1FFFF : quo_q[16:0];
	assign qs   = dneg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

	assign asin_case  = (c_q > SQRT_HALF) || (z_q < LOW_Z_LIMIT);
	assign s_in_range = (s_q >= -NEAR_ONE) && (s_q <= NEAR_ONE);

	assign sh12 = sat16((24'(sh_q) + 24'sd8) >>> 4);
	assign el12 = sat16((24'(el_q) + 24'sd8) >>> 4);
	assign wr   = sat16(24'(wacc_q) - 24'(el12));
	assign shc  = sat16(24'(sh12) - 24'(last_sh_q));
	assign elc  = sat16(24'(el12) - 24'(last_el_q));

	assign fin      = mul_fin_q | sq_fin_q | dv_fin_q | c_fin_q | imm_q;
	assign sts.done = fin;
	assign m_tdata  = {7'b0, out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q   <= 15'd2560;
			fore_q    <= 15'd2560;
			last_sh_q <= '0;
			last_el_q <= '0;
			wacc_q    <= '0;
			imm_q     <= 1'b0;
			mul_run_q <= 1'b0;
			mul_fin_q <= 1'b0;
			sq_run_q  <= 1'b0;
			sq_fin_q  <= 1'b0;
			dv_run_q  <= 1'b0;
			dv_fin_q  <= 1'b0;
			c_run_q   <= 1'b0;
			c_fin_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_UPPER: upper_q <= cfg_data;
					REG_FORE:  fore_q  <= cfg_data;
					default: ;
				endcase
			end
			imm_q     <= cmd.start && !(is_mul || is_sqrt || is_div || is_cord);
			mul_run_q <= cmd.start && is_mul;
			mul_fin_q <= mul_run_q;
			sq_fin_q  <= sq_run_q && (sq_cnt_q == 5'(ROOT_W - 1));
			dv_fin_q  <= dv_run_q && (dv_cnt_q == 6'(DIV_W - 1));
			c_fin_q   <= c_run_q && (c_cnt_q == 4'd15);
			if (cmd.start && is_sqrt) begin
				sq_run_q <= 1'b1;
			end else if (sq_cnt_q == 5'(ROOT_W - 1)) begin
				sq_run_q <= 1'b0;
			end
			if (cmd.start && is_div) begin
				dv_run_q <= 1'b1;
			end else if (dv_cnt_q == 6'(DIV_W - 1)) begin
				dv_run_q <= 1'b0;
			end
			if (cmd.start && is_cord) begin
				c_run_q <= 1'b1;
			end else if (c_cnt_q == 4'd15) begin
				c_run_q <= 1'b0;
			end
			if (fin && op_q == OP_FINISH) begin
				last_sh_q <= sh12;
				last_el_q <= el12;
				wacc_q    <= wr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q   <= $signed(s_tdata[15:0]);
			z_q   <= $signed(s_tdata[31:16]);
			err_q <= 1'b0;
		end
		if (cmd.start) begin
			op_q <= cmd.op;
		end

		if (cmd.start && is_mul) begin
			mul_a_q <= mul_a_d;
			mul_b_q <= mul_b_d;
		end
		if (mul_run_q) begin
			prod_q <= mul_a_q * mul_b_q;
		end

		if (cmd.start && is_sqrt) begin
			rad_q    <= rad_d;
			root_q   <= '0;
			rem_q    <= '0;
			sq_cnt_q <= '0;
		end else if (sq_run_q) begin
			rad_q    <= {rad_q[RAD_W-3:0], 2'b00};
			sq_cnt_q <= sq_cnt_q + 1'b1;
			if (sq_part >= sq_trial) begin
				rem_q  <= 19'(sq_part - sq_trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= sq_part[18:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end

		if (cmd.start && is_div) begin
			dvd_q    <= div_num[49] ? div_neg[DIV_W-1:0] : div_num[DIV_W-1:0];
			dneg_q   <= div_num[49];
			dden_q   <= div_den;
			drem_q   <= '0;
			quo_q    <= '0;
			dv_cnt_q <= '0;
		end else if (dv_run_q) begin
			dvd_q    <= {dvd_q[DIV_W-2:0], 1'b0};
			dv_cnt_q <= dv_cnt_q + 1'b1;
			if (dv_trial >= {1'b0, dden_q}) begin
				drem_q <= DEN_W'(dv_trial - {1'b0, dden_q});
				quo_q  <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				drem_q <= dv_trial[DEN_W-1:0];
				quo_q  <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end

		if (cmd.start && is_cord) begin
			c_cnt_q <= '0;
			if (cmd.op == OP_ROT_SH) begin
				cmode_q <= 1'b1;
				cneg_q  <= fold_neg;
				cx_q    <= CORDIC_GAIN;
				cy_q    <= '0;
				cz_q    <= fold[CORD_W-1:0];
			end else begin
				cmode_q <= 1'b0;
				cneg_q  <= 1'b0;
				cx_q    <= {3'b0, root_q};
				cy_q    <= 20'(u_q);
				cz_q    <= '0;
			end
		end else if (c_run_q) begin
			c_cnt_q <= c_cnt_q + 1'b1;
			if (cmode_q ? !cz_q[CORD_W-1] : cy_q[CORD_W-1]) begin
				cx_q <= cx_q - cys;
				cy_q <= cy_q + cxs;
				cz_q <= cz_q - cat;
			end else begin
				cx_q <= cx_q + cys;
				cy_q <= cy_q - cxs;
				cz_q <= cz_q + cat;
			end
		end

		if (fin) begin
			case (op_q)
				OP_MUL_XX:  r2_q <= prod_q[31:0];
				OP_MUL_ZZ:  r2_q <= r2_q + prod_q[31:0];
				OP_SQRT_R2: len_q <= root_q[15:0];
				OP_MUL_AA:  t_q <= $signed(prod_q[31:0]);
				OP_MUL_FF:  t_q <= t_q - $signed(prod_q[31:0]);
				OP_MUL_AL:  den_q <= {prod_q[30:0], 1'b0};
				OP_DIV_ZR: begin
					if (len_q == '0) begin
						zr_q  <= '0;
						err_q <= 1'b1;
					end else begin
						zr_q <= clamp_unit(qs);
						if (beyond_unit(qs)) err_q <= 1'b1;
					end
				end
				OP_DIV_XR: begin
					if (len_q == '0 || upper_q == '0) begin
						xr_q  <= '0;
						err_q <= 1'b1;
					end else begin
						xr_q <= clamp_unit(qs);
						if (beyond_unit(qs)) err_q <= 1'b1;
					end
				end
				OP_SETU_XR: u_q <= xr_q;
				OP_SAVE_A:  tang_q <= cz_q;
				OP_SETU_ZR: u_q <= zr_q;
				OP_SHOULDER: sh_q <= 22'(tang_q) - ANG_HALF_PI + 22'(cz_q);
				OP_ROT_SH: begin
					co_q <= cneg_q ? -cx_q : cx_q;
					si_q <= cneg_q ? -cy_q : cy_q;
				end
				OP_DIV_C: begin
					if (fore_q == '0) begin
						c_q   <= '0;
						err_q <= 1'b1;
					end else begin
						c_q <= qs;
					end
				end
				OP_DIV_S: s_q <= (fore_q == '0) ? '0 : qs;
				OP_SETU_EL: begin
					acase_q <= asin_case;
					if (asin_case) begin
						u_q <= clamp_unit(s_q);
					end else begin
						u_q <= clamp_unit(c_q);
						if (beyond_unit(c_q)) err_q <= 1'b1;
					end
				end
				OP_ELBOW: begin
					if (!acase_q) begin
						el_q <= ANG_HALF_PI - 22'(cz_q) - sh_q;
					end else if (s_in_range) begin
						el_q <= 22'(cz_q) - sh_q;
					end else begin
						el_q <= -sh_q;
					end
				end
				OP_FINISH: out_q <= {err_q, elc, shc, wr, el12, sh12};
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/two_link_arm_angle_solver.sv =====
// Top level of the two-link planar arm angle solver.
// Each accepted target runs through the whole microprogram before the next target is taken,
// and the next target can be taken in the same cycle its angles appear. A microprogram of 29
// steps runs one after the other; 22 of them use four shared units. The multiplier is used ten
// times. The 17-step square root is used four times. The 49-step restoring divider is used four
// times. The 16-step CORDIC unit is used four times. The other seven steps are register moves.
// A finished result may wait in the output register while the next target runs. The final
// step stalls only while a previous result is still not accepted. Lengths are Q7.8 cm, angles
// Q3.12 rad.
`default_nettype none
module two_link_arm_angle_solver (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// target_x, target_z
	input  wire logic [31:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// shoulder_angle, elbow_angle, wrist_angle, shoulder_change, elbow_change, domain_error
	output logic [87:0]      m_tdata,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [14:0] cfg_data
);
	import tlas_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tlas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	tlas_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tdata   (m_tdata)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted again right after a transaction");

	a_start_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !cmd.start)
		else $error("step started twice in a row");

	a_result_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(sts.done))
		else $error("result raised without a finished step");

endmodule
`default_nettype wire
